// ===== sv/spectrum_gradient_colormap_defines.svh =====
// assertion macros for the spectrum gradient color map checks
`ifndef SPECTRUM_GRADIENT_COLORMAP_DEFINES_SVH
`define SPECTRUM_GRADIENT_COLORMAP_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define SGC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spectrum_gradient_colormap check failed");

// consequent must hold in the same cycle as the antecedent
`define SGC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spectrum_gradient_colormap check failed");

`endif

// ===== sv/sgc_pkg.sv =====
// shared types, constants and helpers of the spectrum gradient color map
`timescale 1ns / 1ps
`default_nettype none

package sgc_pkg;

  // defaults of the top level parameters
  localparam int unsigned MAX_STOPS  = 5;
  localparam int unsigned VALUE_BITS = 16;

  // depth of the queue between front and back end
  localparam int unsigned FIFO_DEPTH = 4;

  // fixed field widths
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned WEIGHT_W  = 13;
  localparam int unsigned MIX_W     = 21;

  // Q0.12 one and rounding half
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 13'd4096;
  localparam logic [MIX_W-1:0]    ROUND_HALF = 21'd2048;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_COUNT = 3'd0,
    CFG_BLOCK_SIZE = 3'd1,
    CFG_CHUNK_STEP = 3'd2,
    CFG_STOP_ZERO  = 3'd3,
    CFG_STOP_ONE   = 3'd4,
    CFG_STOP_TWO   = 3'd5,
    CFG_STOP_THREE = 3'd6,
    CFG_STOP_FOUR  = 3'd7
  } cfg_idx_e;

  // one gradient stop as packed in its register
  typedef struct packed {
    logic [7:0]         alpha;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic [15:0]        inv_width;
    logic [LEVEL_W-1:0] level;
  } stop_t;

  // decimation settings seen by the front end
  typedef struct packed {
    logic [15:0] block_size;
    logic [15:0] chunk_step;
  } dec_cfg_t;

  // blend of two 8-bit channels by a Q0.12 weight, rounding half up
  function automatic logic [7:0] blend(input logic [7:0] lo_c, input logic [7:0] hi_c,
                                       input logic [WEIGHT_W-1:0] w);
    logic [MIX_W-1:0] mix;
    mix = MIX_W'(hi_c) * MIX_W'(w) + MIX_W'(lo_c) * MIX_W'(WEIGHT_ONE - w) + ROUND_HALF;
    return mix[19:12];
  endfunction

endpackage

`default_nettype wire

// ===== sv/spectrum_gradient_colormap.sv =====
// top level of the spectrum gradient color map: config registers and the two ends
// A bin is accepted in every cycle in which the front queue is not full; bins of a
// skipped chunk are dropped in that same cycle. Emitted bins go through a four-entry
// queue and a three-stage back end (clamp and stop search, weight multiply, channel
// blend), so an accepted bin is written into the queue and then registered in each
// stage before its pixel is on the result ports, and pixels leave at one per cycle
// while pop keeps up. Each stage takes a new bin as its last one moves on, which sets
// this one-per-cycle figure; with pop held low, seven emitted bins fit before full
// rises. Configuration may be written only while no emitted bin is still in flight.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_gradient_colormap #(
  parameter int unsigned MaxStops  = sgc_pkg::MAX_STOPS,
  parameter int unsigned ValueBits = sgc_pkg::VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [ValueBits-1:0]   bin_value_i,
  input  logic                          chunk_last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [7:0]                    alpha_o,
  output logic                          strip_end_o,
  input  logic                          cfg_we_i,
  input  logic [sgc_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [sgc_pkg::CFG_W-1:0]     cfg_wdata_i
);

  import sgc_pkg::*;

  logic [2:0]         stop_count_q;
  dec_cfg_t           dec_cfg_q;
  stop_t              stops_q [MaxStops];

  logic               fifo_push, fifo_full, fifo_valid, fifo_pop;
  logic [ValueBits:0] fifo_wdata, fifo_rdata;

  // scalar configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q         <= 3'd2;
      dec_cfg_q.block_size <= 16'd1;
      dec_cfg_q.chunk_step <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_STOP_COUNT: stop_count_q         <= cfg_wdata_i[2:0];
        CFG_BLOCK_SIZE: dec_cfg_q.block_size <= cfg_wdata_i[15:0];
        CFG_CHUNK_STEP: dec_cfg_q.chunk_step <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // stop registers; indexes past the stops built in are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxStops; k++) begin
        stops_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < MaxStops; k++) begin
        if (cfg_we_i && (cfg_addr_i == CFG_IDX_W'(CFG_STOP_ZERO) + CFG_IDX_W'(k))) begin
          stops_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  sgc_front #(
    .ValueBits (ValueBits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .bin_value_i  (bin_value_i),
    .chunk_last_i (chunk_last_i),
    .dec_cfg_i    (dec_cfg_q),
    .fifo_full_i  (fifo_full),
    .fifo_push_o  (fifo_push),
    .fifo_data_o  (fifo_wdata)
  );

  sgc_fifo #(
    .Width (ValueBits + 1),
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .data_o  (fifo_rdata),
    .pop_i   (fifo_pop)
  );

  sgc_back #(
    .MaxStops  (MaxStops),
    .ValueBits (ValueBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_rdata),
    .fifo_pop_o   (fifo_pop),
    .stop_count_i (stop_count_q),
    .stops_i      (stops_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .strip_end_o  (strip_end_o)
  );

endmodule

`default_nettype wire

// ===== sv/sgc_fifo.sv =====
// small register queue between the front and the back end
`timescale 1ns / 1ps
`default_nettype none

module sgc_fifo #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sgc_front.sv =====
// front end: takes bins, runs the decimation counter, queues emitted bins
`timescale 1ns / 1ps
`default_nettype none

module sgc_front #(
  parameter int unsigned ValueBits = sgc_pkg::VALUE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic signed [ValueBits-1:0] bin_value_i,
  input  logic                        chunk_last_i,
  input  sgc_pkg::dec_cfg_t           dec_cfg_i,
  input  logic                        fifo_full_i,
  output logic                        fifo_push_o,
  output logic [ValueBits:0]          fifo_data_o
);

  import sgc_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d;
  logic               emit_q, emit_d;
  logic               start_q, start_d;
  logic               accept;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat;
  logic               pass;

  assign full_o  = fifo_full_i;
  assign accept  = push_i && !fifo_full_i;

  // counter plus chunk step, saturated, against the threshold
  assign sum  = {1'b0, count_q} + (COUNT_W + 1)'(dec_cfg_i.chunk_step);
  assign sat  = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  assign pass = (sat >= COUNT_W'(dec_cfg_i.block_size));

  // chunk state update on each accepted bin
  always_comb begin
    count_d = count_q;
    emit_d  = emit_q;
    start_d = start_q;
    if (accept) begin
      start_d = chunk_last_i;
      if (start_q) begin
        emit_d  = pass;
        count_d = pass ? sat - COUNT_W'(dec_cfg_i.block_size) : sat;
      end
    end
  end

  assign fifo_push_o = accept && (start_q ? pass : emit_q);
  assign fifo_data_o = {chunk_last_i, bin_value_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      emit_q  <= 1'b0;
      start_q <= 1'b1;
    end else begin
      count_q <= count_d;
      emit_q  <= emit_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sgc_back.sv =====
// back end: clamp and stop search, weight multiply, channel blend
`timescale 1ns / 1ps
`default_nettype none

module sgc_back #(
  parameter int unsigned MaxStops  = sgc_pkg::MAX_STOPS,
  parameter int unsigned ValueBits = sgc_pkg::VALUE_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_valid_i,
  input  logic [ValueBits:0]  fifo_data_i,
  output logic                fifo_pop_o,
  input  logic [2:0]          stop_count_i,
  input  sgc_pkg::stop_t      stops_i [MaxStops],
  output logic                empty_o,
  input  logic                pop_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          alpha_o,
  output logic                strip_end_o
);

  import sgc_pkg::*;

  localparam int unsigned StopIdxW = (MaxStops > 1) ? $clog2(MaxStops) : 1;
  localparam int unsigned CmpW     = (ValueBits > LEVEL_W) ? ValueBits : LEVEL_W;

  // stage handshakes
  logic out_ready, s2_ready, s1_ready;

  // stage 1 signals
  logic [2:0]                n_eff;
  logic [StopIdxW-1:0]       last_idx;
  logic signed [ValueBits-1:0] in_val;
  logic                      in_last;
  logic signed [CmpW-1:0]    vx, lvl_first, lvl_last, cl;
  logic signed [LEVEL_W-1:0] val_c, lvl_lo;
  logic [StopIdxW-1:0]       lo_sel;
  logic                      found;
  logic signed [LEVEL_W:0]   diff;

  logic                      s1_valid_q;
  logic [StopIdxW-1:0]       s1_lo_q;
  logic signed [LEVEL_W:0]   s1_diff_q;
  logic                      s1_last_q;

  // stage 2 signals
  logic signed [2*LEVEL_W+1:0] prod;
  logic [2*LEVEL_W-7:0]        q_w;
  logic [WEIGHT_W-1:0]         weight;

  logic                s2_valid_q;
  logic [StopIdxW-1:0] s2_lo_q;
  logic [WEIGHT_W-1:0] s2_w_q;
  logic                s2_last_q;

  // stage 3 signals
  stop_t lo_stop, hi_stop;

  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic       strip_q;

  // ready chain from the result side back to the queue
  assign out_ready  = !out_valid_q || pop_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign fifo_pop_o = fifo_valid_i && s1_ready;

  // number of stops in use, held to two up to the stop count built in
  always_comb begin
    n_eff = stop_count_i;
    if (n_eff < 3'd2) begin
      n_eff = 3'd2;
    end
    if (n_eff > 3'(MaxStops)) begin
      n_eff = 3'(MaxStops);
    end
  end
  assign last_idx = StopIdxW'(n_eff - 3'd1);

  // clamp to the first and last stop levels
  assign in_val    = fifo_data_i[ValueBits-1:0];
  assign in_last   = fifo_data_i[ValueBits];
  assign vx        = CmpW'(in_val);
  assign lvl_first = CmpW'($signed(stops_i[0].level));
  assign lvl_last  = CmpW'($signed(stops_i[last_idx].level));

  always_comb begin
    cl = vx;
    if (cl < lvl_first) begin
      cl = lvl_first;
    end
    if (cl > lvl_last) begin
      cl = lvl_last;
    end
  end
  assign val_c = cl[LEVEL_W-1:0];

  // first stop at or above the value; stop 0 is the fallback lower stop
  always_comb begin
    lo_sel = '0;
    found  = 1'b0;
    for (int j = 1; j < MaxStops; j++) begin
      if (!found && (StopIdxW'(j) <= last_idx) &&
          (val_c <= $signed(stops_i[j].level))) begin
        lo_sel = StopIdxW'(j - 1);
        found  = 1'b1;
      end
    end
  end

  assign lvl_lo = stops_i[lo_sel].level;
  assign diff   = {val_c[LEVEL_W-1], val_c} - {lvl_lo[LEVEL_W-1], lvl_lo};

  // weight from distance times inverse width, saturated to 0..one
  assign prod = s1_diff_q * $signed({1'b0, stops_i[s1_lo_q].inv_width});
  assign q_w  = prod[2*LEVEL_W+1:8];

  always_comb begin
    if (prod <= 0) begin
      weight = '0;
    end else if (q_w > (2*LEVEL_W-6)'(WEIGHT_ONE)) begin
      weight = WEIGHT_ONE;
    end else begin
      weight = q_w[WEIGHT_W-1:0];
    end
  end

  // the two stops around the value
  assign lo_stop = stops_i[s2_lo_q];
  assign hi_stop = stops_i[StopIdxW'(s2_lo_q + 1'b1)];

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= fifo_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) begin
      s1_lo_q   <= lo_sel;
      s1_diff_q <= diff;
      s1_last_q <= in_last;
    end
    if (s2_ready && s1_valid_q) begin
      s2_lo_q   <= s1_lo_q;
      s2_w_q    <= weight;
      s2_last_q <= s1_last_q;
    end
    if (out_ready && s2_valid_q) begin
      red_q   <= blend(lo_stop.red,   hi_stop.red,   s2_w_q);
      green_q <= blend(lo_stop.green, hi_stop.green, s2_w_q);
      blue_q  <= blend(lo_stop.blue,  hi_stop.blue,  s2_w_q);
      alpha_q <= blend(lo_stop.alpha, hi_stop.alpha, s2_w_q);
      strip_q <= s2_last_q;
    end
  end

  assign empty_o     = !out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;
  assign strip_end_o = strip_q;

endmodule

`default_nettype wire

// ===== sv/sgc_checker.sv =====
// port checks of the spectrum gradient color map and their binding
`timescale 1ns / 1ps
`default_nettype none

`include "spectrum_gradient_colormap_defines.svh"

module sgc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic [7:0] alpha_o,
  input logic       strip_end_o
);

  logic        in_beat;
  logic        quiet;
  logic [2:0]  quiet_q, quiet_d;
  logic        quiet_run;
  logic [32:0] pixel;

  assign in_beat = push && !full;
  assign quiet   = empty && !in_beat;
  assign pixel   = {strip_end_o, alpha_o, blue_o, green_o, red_o};

  // three-bit history of the quiet flag
  assign quiet_d   = {quiet_q[1:0], quiet};
  assign quiet_run = quiet && (&quiet_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_q <= '0;
    end else begin
      quiet_q <= quiet_d;
    end
  end

  // the queue only fills up right after an input beat
  `SGC_ASSERT_NOW(a_full_needs_beat, $rose(full), $past(in_beat))

  // with no input beat and no result through the quiet history and this cycle, nothing is left in flight
  `SGC_ASSERT_NEXT(a_quiet_stays_empty, quiet_run, empty)

  // a waiting result holds until taken
  `SGC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(pixel))

endmodule

bind spectrum_gradient_colormap sgc_checker u_sgc_checker (.*);

`default_nettype wire
